// ----- src/ppf_pkg.sv -----
package ppf_pkg;

    localparam int MAX_PARTICLES = 256;
    localparam int IDX_W = 8;
    localparam int CNT_W = 9;
    localparam int DW = 32;
    localparam int DIFF_W = DW + 1;
    localparam int PROD_W = 2 * DW;
    localparam int SQ_W = PROD_W + 2;
    localparam int DOT_W = SQ_W + 1;
    localparam int DEN_W = DW + DIFF_W;
    localparam int NUM_W = SQ_W + 16;
    localparam int QUO_W = 63;
    localparam int REM_W = SQ_W + 1;
    localparam int DIV_LAT = QUO_W + 1;
    localparam int BIG_W = 2 * QUO_W;
    localparam int FM_W = QUO_W + DW;

    localparam logic [1:0] REG_PARTICLE_COUNT = 2'd0;
    localparam logic [1:0] REG_TIME_STEP = 2'd1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [DW-1:0] TIME_STEP_RESET = 32'h0001_0000;
    localparam logic [DW-1:0] NEG_LIMIT = 32'h8000_0000;
    localparam logic [DW-1:0] POS_LIMIT = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [2:0][DW-1:0] pos;
        logic [2:0][DW-1:0] vel;
        logic [DW-1:0]      radius;
        logic [DW-1:0]      mass;
    } entry_t;

    // per-item flags that ride alongside the divider
    typedef struct packed {
        logic               far;
        logic               ok;
        logic               cneg;
        logic [2:0]         dneg;
        logic [2:0]         dpos;
        logic [2:0][DW-1:0] dm;
    } side_t;

    typedef struct packed {
        logic               vld;
        logic [2:0][DW-1:0] frc;
        logic               in_range;
        logic               contact;
    } result_t;

endpackage

// ----- src/ppf_store.sv -----
module ppf_store (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ppf_pkg::IDX_W-1:0] wr_idx,
    input  ppf_pkg::entry_t           wr_data,
    input  logic                      rd_en,
    input  logic [ppf_pkg::IDX_W-1:0] rd_s_idx,
    input  logic [ppf_pkg::IDX_W-1:0] rd_t_idx,
    output ppf_pkg::entry_t           rd_s,
    output ppf_pkg::entry_t           rd_t
);
    import ppf_pkg::*;

    entry_t mem [MAX_PARTICLES];
    entry_t s_reg;
    entry_t t_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            s_reg <= mem[rd_s_idx];
            t_reg <= mem[rd_t_idx];
        end
    end

    assign rd_s = s_reg;
    assign rd_t = t_reg;

endmodule

// ----- src/ppf_geom.sv -----
module ppf_geom (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      vld,
    input  logic                      oor,
    input  ppf_pkg::entry_t           ent_s,
    input  ppf_pkg::entry_t           ent_t,
    input  logic [ppf_pkg::DW-1:0]    time_step,
    output logic                      side_vld,
    output ppf_pkg::side_t            side,
    output logic [ppf_pkg::NUM_W-1:0] num_a,
    output logic [ppf_pkg::NUM_W-1:0] num_b,
    output logic [ppf_pkg::NUM_W-1:0] num_c,
    output logic [ppf_pkg::SQ_W-1:0]  sq,
    output logic [ppf_pkg::SQ_W-1:0]  den_b
);
    import ppf_pkg::*;

    // stage 1: differences
    logic                     vld1_reg, oor1_reg;
    logic [2:0][DIFF_W-1:0]   dp1_reg, dv1_reg, dp1_next, dv1_next;
    logic [DIFF_W-1:0]        rs1_reg, msum1_reg, rs1_next, msum1_next;
    logic [DW-1:0]            ms1_reg, mt1_reg;

    // stage 2: magnitudes
    logic                     vld2_reg, oor2_reg;
    logic [2:0][DW-1:0]       dm2_reg, dvm2_reg, dm2_next, dvm2_next;
    logic [2:0]               xneg2_reg, dneg2_reg, dpos2_reg;
    logic [2:0]               xneg2_next, dneg2_next, dpos2_next;
    logic [DIFF_W-1:0]        rs2_reg, msum2_reg;
    logic [DW-1:0]            ms2_reg, mt2_reg;

    // stage 3: products
    logic                     vld3_reg, oor3_reg;
    logic [2:0][DW-1:0]       dm3_reg;
    logic [2:0]               xneg3_reg, dneg3_reg, dpos3_reg;
    logic [2:0][PROD_W-1:0]   sqp3_reg, pp3_reg, sqp3_next, pp3_next;
    logic [SQ_W-1:0]          rr3_reg;
    logic [PROD_W-1:0]        mm3_reg;
    logic [DEN_W-1:0]         den3_reg;

    // stage 4: sums
    logic                     vld4_reg, oor4_reg;
    logic [2:0][DW-1:0]       dm4_reg;
    logic [2:0]               dneg4_reg, dpos4_reg;
    logic [SQ_W-1:0]          sq4_reg, rr4_reg, sq4_next;
    logic [DOT_W-1:0]         dot4_reg, dot4_next;
    logic [PROD_W-1:0]        mm4_reg;
    logic [DEN_W-1:0]         den4_reg;

    // stage 5: branch and divider operands
    logic                     vld5_reg;
    side_t                    side5_reg, side5_next;
    logic [NUM_W-1:0]         na5_reg, nb5_reg, nc5_reg, na5_next, nb5_next, nc5_next;
    logic [SQ_W-1:0]          sq5_reg, db5_reg, db5_next;

    logic [DIFF_W-1:0]        absd, absv;
    logic                     far, cneg, zero_div;
    logic [DOT_W-1:0]         pmag_w;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dp1_next[i] = {ent_t.pos[i][DW-1], ent_t.pos[i]} - {ent_s.pos[i][DW-1], ent_s.pos[i]};
            dv1_next[i] = {ent_t.vel[i][DW-1], ent_t.vel[i]} - {ent_s.vel[i][DW-1], ent_s.vel[i]};
        end
        rs1_next = {1'b0, ent_s.radius} + {1'b0, ent_t.radius};
        msum1_next = {1'b0, ent_s.mass} + {1'b0, ent_t.mass};
    end

    always_comb
    begin
        absd = '0;
        absv = '0;
        for (int i = 0; i < 3; i++)
        begin
            absd = dp1_reg[i][DIFF_W-1] ? (DIFF_W'(0) - dp1_reg[i]) : dp1_reg[i];
            absv = dv1_reg[i][DIFF_W-1] ? (DIFF_W'(0) - dv1_reg[i]) : dv1_reg[i];
            dm2_next[i] = absd[DW-1:0];
            dvm2_next[i] = absv[DW-1:0];
            dneg2_next[i] = dp1_reg[i][DIFF_W-1];
            dpos2_next[i] = !dp1_reg[i][DIFF_W-1] && (dp1_reg[i] != '0);
            xneg2_next[i] = dp1_reg[i][DIFF_W-1] ^ dv1_reg[i][DIFF_W-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sqp3_next[i] = PROD_W'(dm2_reg[i]) * PROD_W'(dm2_reg[i]);
            pp3_next[i] = PROD_W'(dvm2_reg[i]) * PROD_W'(dm2_reg[i]);
        end
    end

    always_comb
    begin
        sq4_next = SQ_W'(sqp3_reg[0]) + SQ_W'(sqp3_reg[1]) + SQ_W'(sqp3_reg[2]);
        dot4_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (xneg3_reg[i])
            begin
                dot4_next = dot4_next - DOT_W'(pp3_reg[i]);
            end
            else
            begin
                dot4_next = dot4_next + DOT_W'(pp3_reg[i]);
            end
        end
    end

    always_comb
    begin
        far = rr4_reg < sq4_reg;
        cneg = dot4_reg[DOT_W-1];
        pmag_w = cneg ? (DOT_W'(0) - dot4_reg) : dot4_reg;
        zero_div = (sq4_reg == '0) || (den4_reg == '0);

        side5_next.far = far;
        side5_next.ok = !oor4_reg && (far || !zero_div);
        side5_next.cneg = cneg;
        side5_next.dneg = dneg4_reg;
        side5_next.dpos = dpos4_reg;
        side5_next.dm = dm4_reg;

        if (far)
        begin
            na5_next = NUM_W'({dm4_reg[0], 32'd0});
            nb5_next = NUM_W'({dm4_reg[1], 32'd0});
            db5_next = sq4_reg;
        end
        else
        begin
            na5_next = {pmag_w[SQ_W-1:0], 16'd0};
            nb5_next = NUM_W'({mm4_reg, 17'd0});
            db5_next = SQ_W'(den4_reg);
        end
        nc5_next = NUM_W'({dm4_reg[2], 32'd0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oor1_reg <= oor;
            dp1_reg <= dp1_next;
            dv1_reg <= dv1_next;
            rs1_reg <= rs1_next;
            msum1_reg <= msum1_next;
            ms1_reg <= ent_s.mass;
            mt1_reg <= ent_t.mass;

            oor2_reg <= oor1_reg;
            dm2_reg <= dm2_next;
            dvm2_reg <= dvm2_next;
            xneg2_reg <= xneg2_next;
            dneg2_reg <= dneg2_next;
            dpos2_reg <= dpos2_next;
            rs2_reg <= rs1_reg;
            msum2_reg <= msum1_reg;
            ms2_reg <= ms1_reg;
            mt2_reg <= mt1_reg;

            oor3_reg <= oor2_reg;
            dm3_reg <= dm2_reg;
            xneg3_reg <= xneg2_reg;
            dneg3_reg <= dneg2_reg;
            dpos3_reg <= dpos2_reg;
            sqp3_reg <= sqp3_next;
            pp3_reg <= pp3_next;
            rr3_reg <= SQ_W'(rs2_reg) * SQ_W'(rs2_reg);
            mm3_reg <= PROD_W'(ms2_reg) * PROD_W'(mt2_reg);
            den3_reg <= DEN_W'(time_step) * DEN_W'(msum2_reg);

            oor4_reg <= oor3_reg;
            dm4_reg <= dm3_reg;
            dneg4_reg <= dneg3_reg;
            dpos4_reg <= dpos3_reg;
            sq4_reg <= sq4_next;
            dot4_reg <= dot4_next;
            rr4_reg <= rr3_reg;
            mm4_reg <= mm3_reg;
            den4_reg <= den3_reg;

            side5_reg <= side5_next;
            na5_reg <= na5_next;
            nb5_reg <= nb5_next;
            nc5_reg <= nc5_next;
            sq5_reg <= sq4_reg;
            db5_reg <= db5_next;
        end
    end

    assign side_vld = vld5_reg;
    assign side = side5_reg;
    assign num_a = na5_reg;
    assign num_b = nb5_reg;
    assign num_c = nc5_reg;
    assign sq = sq5_reg;
    assign den_b = db5_reg;

endmodule

// ----- src/ppf_div.sv -----
module ppf_div (
    input  logic                      clk,
    input  logic                      en,
    input  logic [ppf_pkg::NUM_W-1:0] num,
    input  logic [ppf_pkg::SQ_W-1:0]  den,
    output logic [ppf_pkg::QUO_W-1:0] quo
);
    import ppf_pkg::*;

    // one quotient bit per stage; result saturates at all ones
    logic [REM_W-1:0] rem_reg [DIV_LAT-1];
    logic [QUO_W-1:0] nlo_reg [DIV_LAT-1];
    logic [SQ_W-1:0]  den_reg [DIV_LAT-1];
    logic [QUO_W-1:0] quo_reg [DIV_LAT];
    logic [DIV_LAT-1:0] ovf_reg;

    logic [REM_W-1:0] trial [DIV_LAT];
    logic [DIV_LAT-1:0] ge;

    always_comb
    begin
        trial[0] = '0;
        ge[0] = 1'b0;
        for (int k = 1; k < DIV_LAT; k++)
        begin
            trial[k] = {rem_reg[k-1][REM_W-2:0], nlo_reg[k-1][QUO_W-1]};
            ge[k] = trial[k] >= REM_W'(den_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= REM_W'(num[NUM_W-1:QUO_W]);
            nlo_reg[0] <= num[QUO_W-1:0];
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            ovf_reg[0] <= SQ_W'(num[NUM_W-1:QUO_W]) >= den;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                if (k < DIV_LAT - 1)
                begin
                    rem_reg[k] <= ge[k] ? (trial[k] - REM_W'(den_reg[k-1])) : trial[k];
                    nlo_reg[k] <= {nlo_reg[k-1][QUO_W-2:0], 1'b0};
                    den_reg[k] <= den_reg[k-1];
                end
                quo_reg[k] <= {quo_reg[k-1][QUO_W-2:0], ge[k]};
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quo = ovf_reg[DIV_LAT-1] ? '1 : quo_reg[DIV_LAT-1];

endmodule

// ----- src/ppf_back.sv -----
module ppf_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      vld,
    input  ppf_pkg::side_t            side,
    input  logic [ppf_pkg::QUO_W-1:0] qa,
    input  logic [ppf_pkg::QUO_W-1:0] qb,
    input  logic [ppf_pkg::QUO_W-1:0] qc,
    output ppf_pkg::result_t          res
);
    import ppf_pkg::*;

    localparam int HI_W = QUO_W - DW;

    logic [3:0]           vld_reg;
    side_t                side_reg [4];
    logic [2:0][DW-1:0]   dist_reg [4];
    logic [2:0][DW-1:0]   dist_next;

    // c*k partial products
    logic [PROD_W-1:0]    p00_reg;
    logic [DW+HI_W-1:0]   p01_reg, p10_reg;
    logic [2*HI_W-1:0]    p11_reg;
    logic [BIG_W-1:0]     prod_reg;

    logic [QUO_W-1:0]     m1;
    logic [2:0][PROD_W-1:0]    plo_reg;
    logic [2:0][DW+HI_W-1:0]   phi_reg;
    logic [2:0][DW-1:0]   fm_reg, fm_next;
    logic [FM_W-1:0]      full;

    logic [2:0][QUO_W-1:0] qv;
    logic [DW-1:0]        mag;
    logic                 neg;

    always_comb
    begin
        qv = {qc, qb, qa};
        for (int i = 0; i < 3; i++)
        begin
            dist_next[i] = (|qv[i][QUO_W-1:DW-1]) ? NEG_LIMIT : qv[i][DW-1:0];
        end
    end

    always_comb
    begin
        m1 = (|prod_reg[BIG_W-1:QUO_W+16]) ? '1 : prod_reg[QUO_W+15:16];
    end

    always_comb
    begin
        full = '0;
        for (int i = 0; i < 3; i++)
        begin
            full = FM_W'(plo_reg[i]) + (FM_W'(phi_reg[i]) << DW);
            fm_next[i] = (|full[FM_W-1:DW+15]) ? NEG_LIMIT : full[DW+15:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side;
            dist_reg[0] <= dist_next;
            for (int k = 1; k < 4; k++)
            begin
                side_reg[k] <= side_reg[k-1];
                dist_reg[k] <= dist_reg[k-1];
            end

            p00_reg <= PROD_W'(qa[DW-1:0]) * PROD_W'(qb[DW-1:0]);
            p01_reg <= (DW+HI_W)'(qa[DW-1:0]) * (DW+HI_W)'(qb[QUO_W-1:DW]);
            p10_reg <= (DW+HI_W)'(qa[QUO_W-1:DW]) * (DW+HI_W)'(qb[DW-1:0]);
            p11_reg <= (2*HI_W)'(qa[QUO_W-1:DW]) * (2*HI_W)'(qb[QUO_W-1:DW]);

            prod_reg <= BIG_W'(p00_reg) + ((BIG_W'(p01_reg) + BIG_W'(p10_reg)) << DW)
                      + (BIG_W'(p11_reg) << (2 * DW));

            // prod_reg lines up with side_reg[1]
            for (int i = 0; i < 3; i++)
            begin
                plo_reg[i] <= PROD_W'(m1[DW-1:0]) * PROD_W'(side_reg[1].dm[i]);
                phi_reg[i] <= (DW+HI_W)'(m1[QUO_W-1:DW]) * (DW+HI_W)'(side_reg[1].dm[i]);
            end

            fm_reg <= fm_next;
        end
    end

    // sign and clamp; magnitudes are at most 2^31 here
    always_comb
    begin
        mag = '0;
        neg = 1'b0;
        res.vld = vld_reg[3];
        res.in_range = side_reg[3].ok;
        res.contact = side_reg[3].ok && !side_reg[3].far;
        for (int i = 0; i < 3; i++)
        begin
            mag = side_reg[3].far ? dist_reg[3][i] : fm_reg[i];
            neg = side_reg[3].far ? side_reg[3].dpos[i]
                                  : (side_reg[3].cneg == side_reg[3].dneg[i]);
            if (!side_reg[3].ok)
            begin
                res.frc[i] = '0;
            end
            else if (neg)
            begin
                res.frc[i] = DW'(0) - mag;
            end
            else
            begin
                res.frc[i] = mag[DW-1] ? POS_LIMIT : mag;
            end
        end
    end

endmodule

// ----- src/pairwise_particle_force.sv -----
// Pairwise particle force unit, signed Q16.16.
// Input channel (in_valid/in_ready): action 0 writes entry first_index with
// position, velocity, radius and mass; action 1 asks for the force of particle
// first_index on particle second_index. Writes give no output word; each query
// gives one output word (force_x/y/z, in_range, contact) in query order.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 particle_count,
// index 1 time_step. Write config only while no query is in flight.
// A query passes the table read, 5 geometry stages, 64 divider stages,
// 4 multiply stages and the output register. Throughput: one word per
// cycle while the output is not blocked, set by the pipelined
// one-bit-per-stage dividers.
// If the receiver stalls, the pipeline keeps filling bubbles and in_ready
// drops only once a finished result waits behind a full output register.
// Reset clears valid bits and config (count 0, time step 1.0); the particle
// table is not cleared and entries must be written before they are queried.
module pairwise_particle_force (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [7:0]         first_index,
    input  logic [7:0]         second_index,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic [31:0]        radius,
    input  logic [31:0]        mass,

    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] force_x,
    output logic signed [31:0] force_y,
    output logic signed [31:0] force_z,
    output logic               in_range,
    output logic               contact,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import ppf_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [DW-1:0]    ts_reg;

    logic             adv, accept, wr_en;
    entry_t           wr_data, rd_s, rd_t;
    logic             s1_vld_reg, s1_oor_reg, oor_next;

    logic             g_vld;
    side_t            g_side;
    logic [NUM_W-1:0] num_a, num_b, num_c;
    logic [SQ_W-1:0]  sq, den_b;
    logic [QUO_W-1:0] qa, qb, qc;

    logic [DIV_LAT-1:0] dvld_reg;
    side_t            dside_reg [DIV_LAT];

    result_t          res;
    logic             out_valid_reg;
    logic [2:0][DW-1:0] frc_reg;
    logic             in_range_reg, contact_reg;

    // the whole pipe shifts unless a finished word is blocked
    assign adv = !res.vld || !out_valid_reg || out_ready;
    assign in_ready = adv;
    assign accept = in_valid && adv;
    assign wr_en = accept && (action == ACT_WRITE)
                 && (CNT_W'(first_index) < CNT_W'(MAX_PARTICLES));
    assign oor_next = (CNT_W'(first_index) >= count_reg) || (CNT_W'(second_index) >= count_reg)
                    || (CNT_W'(first_index) >= CNT_W'(MAX_PARTICLES))
                    || (CNT_W'(second_index) >= CNT_W'(MAX_PARTICLES));

    assign wr_data.pos = {pos_z, pos_y, pos_x};
    assign wr_data.vel = {vel_z, vel_y, vel_x};
    assign wr_data.radius = radius;
    assign wr_data.mass = mass;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ts_reg <= TIME_STEP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PARTICLE_COUNT: count_reg <= cfg_data[CNT_W-1:0];
                REG_TIME_STEP:      ts_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    ppf_store u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_idx   (first_index),
        .wr_data  (wr_data),
        .rd_en    (adv),
        .rd_s_idx (first_index),
        .rd_t_idx (second_index),
        .rd_s     (rd_s),
        .rd_t     (rd_t)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_valid && (action == ACT_QUERY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_oor_reg <= oor_next;
        end
    end

    ppf_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .vld       (s1_vld_reg),
        .oor       (s1_oor_reg),
        .ent_s     (rd_s),
        .ent_t     (rd_t),
        .time_step (ts_reg),
        .side_vld  (g_vld),
        .side      (g_side),
        .num_a     (num_a),
        .num_b     (num_b),
        .num_c     (num_c),
        .sq        (sq),
        .den_b     (den_b)
    );

    ppf_div u_div_a (.clk(clk), .en(adv), .num(num_a), .den(sq),    .quo(qa));
    ppf_div u_div_b (.clk(clk), .en(adv), .num(num_b), .den(den_b), .quo(qb));
    ppf_div u_div_c (.clk(clk), .en(adv), .num(num_c), .den(sq),    .quo(qc));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvld_reg <= '0;
        end
        else if (adv)
        begin
            dvld_reg <= {dvld_reg[DIV_LAT-2:0], g_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dside_reg[0] <= g_side;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                dside_reg[k] <= dside_reg[k-1];
            end
        end
    end

    ppf_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .vld   (dvld_reg[DIV_LAT-1]),
        .side  (dside_reg[DIV_LAT-1]),
        .qa    (qa),
        .qb    (qb),
        .qc    (qc),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= res.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            frc_reg <= res.frc;
            in_range_reg <= res.in_range;
            contact_reg <= res.contact;
        end
    end

    assign out_valid = out_valid_reg;
    assign force_x = frc_reg[0];
    assign force_y = frc_reg[1];
    assign force_z = frc_reg[2];
    assign in_range = in_range_reg;
    assign contact = contact_reg;

endmodule

// ----- dv/pairwise_particle_force_tb.sv -----
module pairwise_particle_force_tb;
    import ppf_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd2;
    localparam int DRAIN_CYCLES = 90;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;

    typedef struct {
        bit [31:0] p[3];
        bit [31:0] v[3];
        bit [31:0] r;
        bit [31:0] m;
    } particle_t;

    typedef struct {
        bit [31:0] f[3];
        bit        in_range;
        bit        contact;
    } force_word_t;

    typedef bit [255:0] wide_t;

    class pair_force_book;
        bit [31:0] pos[256][3];
        bit [31:0] vel[256][3];
        bit [31:0] rad[256];
        bit [31:0] mas[256];
        bit [8:0] count;
        bit [31:0] tstep;
        force_word_t expected_forces[$];
        int errors;

        function new();
            count = 0;
            tstep = TIME_STEP_RESET;
            errors = 0;
        endfunction

        function void set_reg(bit [1:0] idx, bit [31:0] data);
            if (idx == REG_PARTICLE_COUNT)
                count = data[8:0];
            else if (idx == REG_TIME_STEP)
                tstep = data;
        endfunction

        function wide_t sat(wide_t a, wide_t lim);
            return (a > lim) ? lim : a;
        endfunction

        function bit [31:0] pack(bit neg, wide_t mag);
            wide_t t;
            if (neg)
            begin
                t = sat(mag, 256'h8000_0000);
                t = ~t + 1;
                return t[31:0];
            end
            t = sat(mag, 256'h7FFF_FFFF);
            return t[31:0];
        endfunction

        function force_word_t predict_force(bit [7:0] s, bit [7:0] t);
            force_word_t r;
            longint d[3], dv[3];
            wide_t dm[3], dvm, sq, rr, dotp, dotn, pmag, den, ms, mt, cm, km, m1, q, rs;
            bit cneg;
            int i;
            for (i = 0; i < 3; i++)
                r.f[i] = 0;
            r.in_range = 0;
            r.contact = 0;
            if (s >= count || t >= count)
                return r;
            sq = 0;
            dotp = 0;
            dotn = 0;
            for (i = 0; i < 3; i++)
            begin
                d[i] = longint'($signed(pos[t][i])) - longint'($signed(pos[s][i]));
                dv[i] = longint'($signed(vel[t][i])) - longint'($signed(vel[s][i]));
                dm[i] = (d[i] < 0) ? -d[i] : d[i];
                dvm = (dv[i] < 0) ? -dv[i] : dv[i];
                sq += dm[i] * dm[i];
                if ((dv[i] < 0) != (d[i] < 0))
                    dotn += dvm * dm[i];
                else
                    dotp += dvm * dm[i];
            end
            rs = rad[s];
            rs += rad[t];
            rr = rs * rs;
            if (rr < sq)
            begin
                for (i = 0; i < 3; i++)
                begin
                    q = sat((dm[i] << 32) / sq, 256'h8000_0000);
                    r.f[i] = pack(d[i] > 0, q);
                end
                r.in_range = 1;
                return r;
            end
            ms = mas[s];
            mt = mas[t];
            den = (ms + mt) * tstep;
            if (sq == 0 || den == 0)
                return r;
            cneg = dotn > dotp;
            pmag = cneg ? dotn - dotp : dotp - dotn;
            cm = sat((pmag << 16) / sq, 256'h7FFF_FFFF_FFFF_FFFF);
            km = sat(((ms * mt) << 17) / den, 256'h7FFF_FFFF_FFFF_FFFF);
            m1 = sat((cm * km) >> 16, 256'h7FFF_FFFF_FFFF_FFFF);
            for (i = 0; i < 3; i++)
                r.f[i] = pack(cneg == (d[i] < 0), sat((m1 * dm[i]) >> 16, 256'h8000_0000));
            r.in_range = 1;
            r.contact = 1;
            return r;
        endfunction

        function void note_word(bit act, bit [7:0] fi, bit [7:0] si, particle_t e);
            int i;
            if (act == ACT_WRITE)
            begin
                for (i = 0; i < 3; i++)
                begin
                    pos[fi][i] = e.p[i];
                    vel[fi][i] = e.v[i];
                end
                rad[fi] = e.r;
                mas[fi] = e.m;
            end
            else
                expected_forces.insert(expected_forces.size(), predict_force(fi, si));
        endfunction

        function void check_word(force_word_t got);
            force_word_t exp_w;
            int i;
            if (expected_forces.size() == 0)
            begin
                $display("%0t: output word with none expected", $time);
                errors++;
                return;
            end
            exp_w = expected_forces.pop_front();
            for (i = 0; i < 3; i++)
                if (got.f[i] !== exp_w.f[i])
                begin
                    $display("%0t: force[%0d] expected %h actual %h",
                             $time, i, exp_w.f[i], got.f[i]);
                    errors++;
                end
            if (got.in_range !== exp_w.in_range)
            begin
                $display("%0t: in_range expected %b actual %b",
                         $time, exp_w.in_range, got.in_range);
                errors++;
            end
            if (got.contact !== exp_w.contact)
            begin
                $display("%0t: contact expected %b actual %b",
                         $time, exp_w.contact, got.contact);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    logic action = 0;
    logic [7:0] first_index = 0;
    logic [7:0] second_index = 0;
    logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
    logic signed [31:0] vel_x = 0, vel_y = 0, vel_z = 0;
    logic [31:0] radius = 0;
    logic [31:0] mass = 0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [31:0] force_x, force_y, force_z;
    logic in_range, contact;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [1:0] cfg_index = 0;
    logic [31:0] cfg_data = 0;

    pair_force_book book = new();
    bit calm = 0;
    bit hold_output = 0;
    int idle_cycles = 0;

    pairwise_particle_force DUT (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side
    initial
    begin
        force_word_t got;
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 19);
            if (hold_output)
            begin
                stall = HOLD_CYCLES;
                hold_output = 0;
            end
            if (stall > 0)
            begin
                out_ready <= 0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1;
            do @(posedge clk); while (!out_valid);
            got.f[0] = force_x;
            got.f[1] = force_y;
            got.f[2] = force_z;
            got.in_range = in_range;
            got.contact = contact;
            book.check_word(got);
        end
    end

    function automatic bit [31:0] signed_span(int bits);
        return $urandom_range(0, (1 << (bits + 1)) - 1) - (1 << bits);
    endfunction

    // tight cluster so pairs often touch; mass sometimes zero
    function automatic particle_t make_particle(bit clustered);
        particle_t e;
        int i;
        for (i = 0; i < 3; i++)
        begin
            e.p[i] = clustered ? signed_span(20) : $urandom;
            e.v[i] = ($urandom_range(0, 1) == 0) ? signed_span(18) : $urandom;
        end
        e.r = clustered ? $urandom_range(0, 1 << 20) : $urandom;
        case ($urandom_range(0, 5))
            0: e.m = 0;
            1: e.m = $urandom;
            2: e.m = 32'hFFFF_FFFF;
            default: e.m = $urandom_range(1, 1 << 20);
        endcase
        return e;
    endfunction

    task automatic send_word(bit act, bit [7:0] fi, bit [7:0] si, particle_t e);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        action <= act;
        first_index <= fi;
        second_index <= si;
        pos_x <= e.p[0];
        pos_y <= e.p[1];
        pos_z <= e.p[2];
        vel_x <= e.v[0];
        vel_y <= e.v[1];
        vel_z <= e.v[2];
        radius <= e.r;
        mass <= e.m;
        do @(posedge clk); while (!in_ready);
        book.note_word(act, fi, si, e);
    endtask

    task automatic write_entry(bit [7:0] idx, particle_t e);
        send_word(ACT_WRITE, idx, 8'($urandom), e);
    endtask

    task automatic query(bit [7:0] s, bit [7:0] t);
        particle_t e;
        e = make_particle(1'($urandom_range(0, 1)));
        send_word(ACT_QUERY, s, t, e);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (book.expected_forces.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(bit [1:0] idx, bit [31:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        book.set_reg(idx, data);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic random_phase(int n_items);
        int k;
        int cl;
        bit [7:0] s, t;
        for (k = 0; k < n_items; k++)
        begin
            cl = (book.count < 64) ? book.count : 64;
            if ($urandom_range(0, 3) == 0)
            begin
                s = 8'($urandom);
                write_entry(s, make_particle(s < 64));
            end
            else
            begin
                if (cl > 0 && $urandom_range(0, 1) == 0)
                begin
                    s = 8'($urandom_range(0, cl - 1));
                    t = 8'($urandom_range(0, cl - 1));
                end
                else
                begin
                    s = 8'($urandom);
                    t = 8'($urandom);
                    if (book.count > 0 && $urandom_range(0, 3) != 0)
                    begin
                        s = 8'(s % book.count);
                        t = 8'(t % book.count);
                    end
                end
                if ($urandom_range(0, 15) == 0)
                    t = s;
                query(s, t);
            end
        end
    endtask

    initial
    begin
        particle_t e;
        int i;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // fill the whole table first so no query ever touches a stale entry
        for (i = 0; i < 256; i++)
            write_entry(8'(i), make_particle(i < 64));
        query(0, 0);
        query(255, 3);
        drain();
        write_reg(REG_PARTICLE_COUNT, 256);

        // directed cases
        for (i = 0; i < 3; i++)
        begin
            e.p[i] = 32'h7FFF_FFFF;
            e.v[i] = 32'h7FFF_FFFF;
        end
        e.r = 0;
        e.m = 32'hFFFF_FFFF;
        write_entry(0, e);
        for (i = 0; i < 3; i++)
        begin
            e.p[i] = 32'h8000_0000;
            e.v[i] = 32'h8000_0000;
        end
        write_entry(1, e);
        e.r = 32'hFFFF_FFFF;
        write_entry(2, e);
        e.r = 0;
        e.m = 0;
        write_entry(3, e);
        for (i = 0; i < 3; i++)
            e.p[i] = 32'h8000_0001;
        write_entry(4, e);
        e.r = 32'hFFFF_FFFF;
        e.m = 32'hFFFF_FFFF;
        for (i = 0; i < 3; i++)
            e.v[i] = 32'h7FFF_FFFF;
        write_entry(5, e);
        query(0, 1);
        query(1, 0);
        query(1, 2);
        query(2, 2);
        query(1, 3);
        query(3, 4);
        query(4, 5);
        query(5, 4);
        query(2, 0);
        query(0, 2);
        drain();

        write_reg(REG_PARTICLE_COUNT, 200);
        query(199, 0);
        query(200, 0);
        query(0, 255);
        drain();

        // receiver holds off while sender keeps pushing
        write_reg(REG_TIME_STEP, 1);
        write_reg(REG_PARTICLE_COUNT, 256);
        hold_output = 1;
        random_phase(120);
        drain();

        write_reg(REG_TIME_STEP, 32'hFFFF_FFFF);
        calm = 1;
        random_phase(100);
        drain();
        calm = 0;

        write_reg(REG_TIME_STEP, 0);
        write_reg(REG_PARTICLE_COUNT, 100);
        random_phase(100);
        drain();

        write_reg(REG_SPARE, $urandom);
        write_reg(REG_TIME_STEP, $urandom);
        write_reg(REG_PARTICLE_COUNT, 2);
        random_phase(80);
        drain();

        write_reg(REG_PARTICLE_COUNT, 0);
        random_phase(30);
        drain();

        write_reg(REG_PARTICLE_COUNT, 256);
        write_reg(REG_TIME_STEP, TIME_STEP_RESET);
        random_phase(40);
        drain();

        write_reg(REG_PARTICLE_COUNT, 64);
        write_reg(REG_TIME_STEP, $urandom_range(1, 1 << 18));
        calm = 1;
        random_phase(60);
        calm = 0;
        random_phase(60);
        drain();

        if (book.errors == 0 && book.expected_forces.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
